>>> rtl/lrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared widths and the search word that walks down the LRU stack chain.
// ----------------------------------------------------------------------------
package lrs_pkg;

  localparam int ADDR_W   = 48;
  localparam int DIST_W   = 6;
  localparam int DIST_MAX = 63;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DIST_W-1:0] dist_t;

  // One word in flight through the stack cells
  typedef struct packed {
    logic  valid;     // slot holds a word
    logic  done;      // hit found or free cell taken; no more shifting
    logic  no_reuse;  // stays set unless a hit is found
    dist_t distance;  // saturated hit depth
    addr_t search;    // address being looked up
    addr_t carry;     // entry pushed down from the cell above
  } token_t;

endpackage

>>> rtl/lrs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_if
// Valid/ready channels for trace addresses and reuse distance results.
// ----------------------------------------------------------------------------
interface lrs_addr_if;
  logic           valid;
  logic           ready;
  lrs_pkg::addr_t address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface lrs_dist_if;
  logic           valid;
  logic           ready;
  lrs_pkg::dist_t distance;
  logic           no_reuse;

  modport source (output valid, output distance, output no_reuse, input ready);
  modport sink   (input valid, input distance, input no_reuse, output ready);
endinterface

>>> rtl/lru_stack_reuse_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_stack_reuse_distance
// LRU stack distance of an address trace, built as a systolic chain of
// stack cells. Each address walks down one cell per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel  dir  payload             handshake
//  trace    in   address[47:0]       valid/ready
//  result   out  distance[5:0],      valid/ready
//                no_reuse
//
//  One address accepted per cycle unless the result side stalls; each
//  result leaves the last cell after its address has passed the whole chain.
//  Reset clears the fill count and the valid bits of the in-flight slots.
//  A stalled result freezes the whole chain and drops trace.ready.
// ----------------------------------------------------------------------------
module lru_stack_reuse_distance #(
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  lrs_addr_if.sink   trace,
  lrs_dist_if.source result
);

  localparam int FILL_W = $clog2(STACK_DEPTH + 1);

  lrs_pkg::token_t          tokens [STACK_DEPTH+1];
  logic [STACK_DEPTH-1:0]   absorbs;
  logic [FILL_W-1:0]        fill;
  logic [FILL_W-1:0]        fill_next;
  logic                     advance;

  // Chain moves unless the last word is waiting on the consumer
  assign advance     = !tokens[STACK_DEPTH].valid || result.ready;
  assign trace.ready = advance;

  // Launch a new word at the top of the stack
  always_comb begin
    tokens[0]          = '0;
    tokens[0].valid    = trace.valid;
    tokens[0].no_reuse = 1'b1;
    tokens[0].search   = trace.address;
    tokens[0].carry    = trace.address;
  end

  // Stack cells
  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
    lrs_cell #(
      .INDEX  (k),
      .FILL_W (FILL_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .fill      (fill),
      .token_in  (tokens[k]),
      .token_out (tokens[k+1]),
      .absorb    (absorbs[k])
    );
  end

  // Count live entries; at most one free cell is taken per cycle
  always_comb begin
    fill_next = fill;
    if (advance && (|absorbs)) begin
      fill_next = fill + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // Last slot is the output register
  assign result.valid    = tokens[STACK_DEPTH].valid;
  assign result.distance = tokens[STACK_DEPTH].distance;
  assign result.no_reuse = tokens[STACK_DEPTH].no_reuse;

endmodule

>>> rtl/lrs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_cell
// One LRU stack entry: compares the passing word, swaps its entry with the
// carried one, and hands the word to the next cell.
// ----------------------------------------------------------------------------
module lrs_cell #(
  parameter int INDEX  = 0,
  parameter int FILL_W = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [FILL_W-1:0] fill,
  input  lrs_pkg::token_t   token_in,
  output lrs_pkg::token_t   token_out,
  output logic              absorb
);

  localparam int DIST_SAT = (INDEX > lrs_pkg::DIST_MAX) ? lrs_pkg::DIST_MAX : INDEX;

  lrs_pkg::addr_t  entry;
  lrs_pkg::token_t token_next;
  logic            occupied;
  logic            active;
  logic            hit;

  // Entry is live only below the fill count
  assign occupied = FILL_W'(INDEX) < fill;
  assign active   = token_in.valid && !token_in.done;
  assign hit      = active && occupied && (entry == token_in.search);
  assign absorb   = active && !occupied;

  // Build the word for the next cell
  always_comb begin
    token_next = token_in;
    if (active) begin
      token_next.carry = entry;
      if (hit) begin
        token_next.done     = 1'b1;
        token_next.no_reuse = 1'b0;
        token_next.distance = lrs_pkg::DIST_W'(DIST_SAT);
      end else if (!occupied) begin
        token_next.done = 1'b1;
      end
    end
  end

  // Take the carried entry whenever the chain advances and the word is still shifting
  always_ff @(posedge clk) begin
    if (advance && active) begin
      entry <= token_in.carry;
    end
  end

  // Advance the word
  always_ff @(posedge clk) begin
    if (rst) begin
      token_out.valid <= 1'b0;
    end else if (advance) begin
      token_out <= token_next;
    end
  end

endmodule

>>> rtl/lrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_checker
// Port-level checks on the reuse distance block, bound to the top level.
// ----------------------------------------------------------------------------
module lrs_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input lrs_pkg::dist_t distance,
  input logic           no_reuse
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(no_reuse))
    else $error("result word changed while stalled");

  // Report zero distance on no reuse
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_reuse |-> distance == '0)
    else $error("nonzero distance on no reuse");

  // Take trace words exactly when the chain can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("trace ready out of step with result side");

  // Come out of reset empty
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lru_stack_reuse_distance lrs_checker u_lrs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (trace.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .distance  (result.distance),
  .no_reuse  (result.no_reuse)
);
